/* rtl/core/tcfe_pkg.sv */
// Shared types and constants for the tile cache with farthest-distance eviction.
package tcfe_pkg;

  // Default sizes
  localparam int CACHE_SLOTS_DEF = 16;
  localparam int GRID_SIZE_DEF   = 64;

  // Fixed field widths
  localparam int IN_COORD_W = 8;
  localparam int MASK_W     = 9;
  localparam int NBR_W      = 4;
  localparam int SLOT_OUT_W = 4;
  localparam int EV_COORD_W = 6;

  // Signed width for neighbour arithmetic (covers -129 .. 128)
  localparam int POS_W = 10;

  // Neighbourhood positions
  localparam logic [NBR_W-1:0] NBR_FIRST  = 4'd0;
  localparam logic [NBR_W-1:0] NBR_CENTRE = 4'd4;
  localparam logic [NBR_W-1:0] NBR_LAST   = 4'd8;
  localparam logic [1:0]       COL_LAST   = 2'd2;

  // Eviction search handles this many slots per cycle
  localparam int SCAN_LANES = 8;

  // Queue depths
  localparam int CMD_DEPTH = 4;
  localparam int RES_DEPTH = 2;

  typedef enum logic {
    CMD_PASS,
    CMD_LOOK
  } cmd_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DECIDE,
    BK_SCAN,
    BK_EVICT
  } bk_state_t;

  // One neighbour job from the front end
  typedef struct packed {
    cmd_kind_t              kind;
    logic [NBR_W-1:0]       idx;
    logic                   oob;
    logic                   last;
    logic [IN_COORD_W-1:0]  nx;
    logic [IN_COORD_W-1:0]  nz;
    logic [IN_COORD_W-1:0]  cx;
    logic [IN_COORD_W-1:0]  cz;
  } cmd_t;

  // One result transaction
  typedef struct packed {
    logic [NBR_W-1:0]      neighbour_index;
    logic                  out_of_bounds;
    logic                  loaded;
    logic                  hit;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  evicted;
    logic [EV_COORD_W-1:0] evicted_x;
    logic [EV_COORD_W-1:0] evicted_z;
    logic                  last;
  } res_t;

endpackage

/* rtl/core/tile_cache_farthest_eviction.sv */
// Tile cache with farthest-distance eviction: top level.
//
// Input channel: an event (enter_x, enter_z, exists_mask) is taken on a rising
// edge with push high and full low. Result channel: while empty is low the
// oldest result is on the result ports; pop with empty low takes it.
// An event whose centre is off the grid gives one result; any other event
// gives nine, one per neighbour in row order, the ninth with last set.
// The front end splits an event into neighbour jobs (a single job for an
// off-grid centre) and takes the next event once the last job is queued.
// The back end otherwise sets the throughput: a skipped neighbour is retired
// from the idle state, a hit or fill passes through the decide state, and an
// eviction through decide, scan and evict, as the farthest-entry search folds
// eight slots per cycle. Reset empties both queues and invalidates every slot.
// When the receiver stops popping, the two-entry result queue fills, the back
// end stalls, the job queue fills and full stays high.
module tile_cache_farthest_eviction #(
  parameter int CACHE_SLOTS = tcfe_pkg::CACHE_SLOTS_DEF,
  parameter int GRID_SIZE   = tcfe_pkg::GRID_SIZE_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  output logic                                   full,
  input  logic signed [tcfe_pkg::IN_COORD_W-1:0] enter_x,
  input  logic signed [tcfe_pkg::IN_COORD_W-1:0] enter_z,
  input  logic [tcfe_pkg::MASK_W-1:0]            exists_mask,
  output logic                                   empty,
  input  logic                                   pop,
  output logic [tcfe_pkg::NBR_W-1:0]             neighbour_index,
  output logic                                   out_of_bounds,
  output logic                                   loaded,
  output logic                                   hit,
  output logic [tcfe_pkg::SLOT_OUT_W-1:0]        slot,
  output logic                                   evicted,
  output logic [tcfe_pkg::EV_COORD_W-1:0]        evicted_x,
  output logic [tcfe_pkg::EV_COORD_W-1:0]        evicted_z,
  output logic                                   last
);

  import tcfe_pkg::*;

  cmd_t             fe_cmd;
  logic             fe_push;
  logic             cq_full;
  logic [$bits(cmd_t)-1:0] cq_rdata;
  logic             cq_empty;
  logic             be_pop;
  res_t             be_res;
  logic             be_push;
  logic             rq_full;
  logic [$bits(res_t)-1:0] rq_rdata;
  res_t             out_res;

  // Split events into neighbour jobs
  tcfe_front #(
    .GRID_SIZE(GRID_SIZE)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .enter_x     (enter_x),
    .enter_z     (enter_z),
    .exists_mask (exists_mask),
    .cmd_push    (fe_push),
    .cmd         (fe_cmd),
    .cmd_full    (cq_full)
  );

  // Decouple front and back end
  tcfe_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (fe_push),
    .wdata (fe_cmd),
    .full  (cq_full),
    .pop   (be_pop),
    .rdata (cq_rdata),
    .empty (cq_empty)
  );

  // Lookup, fill and evict
  tcfe_back #(
    .CACHE_SLOTS(CACHE_SLOTS),
    .GRID_SIZE  (GRID_SIZE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_t'(cq_rdata)),
    .cmd_empty (cq_empty),
    .cmd_pop   (be_pop),
    .res       (be_res),
    .res_push  (be_push),
    .res_full  (rq_full)
  );

  // Hold results until popped
  tcfe_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (be_push),
    .wdata (be_res),
    .full  (rq_full),
    .pop   (pop),
    .rdata (rq_rdata),
    .empty (empty)
  );

  assign out_res         = res_t'(rq_rdata);
  assign neighbour_index = out_res.neighbour_index;
  assign out_of_bounds   = out_res.out_of_bounds;
  assign loaded          = out_res.loaded;
  assign hit             = out_res.hit;
  assign slot            = out_res.slot;
  assign evicted         = out_res.evicted;
  assign evicted_x       = out_res.evicted_x;
  assign evicted_z       = out_res.evicted_z;
  assign last            = out_res.last;

endmodule

/* rtl/core/tcfe_fifo.sv */
// Small synchronous queue used between the front end, the back end and the result port.
module tcfe_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_LAST) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_LAST) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Hold entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

/* rtl/core/tcfe_front.sv */
// Front end: accepts tile-enter events and splits them into per-neighbour jobs.
module tcfe_front #(
  parameter int GRID_SIZE = tcfe_pkg::GRID_SIZE_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [tcfe_pkg::IN_COORD_W-1:0] enter_x,
  input  logic signed [tcfe_pkg::IN_COORD_W-1:0] enter_z,
  input  logic [tcfe_pkg::MASK_W-1:0]           exists_mask,
  output logic                                  cmd_push,
  output tcfe_pkg::cmd_t                        cmd,
  input  logic                                  cmd_full
);

  import tcfe_pkg::*;

  localparam logic signed [POS_W-1:0] GRID_LIM = POS_W'(GRID_SIZE);
  localparam logic signed [POS_W-1:0] ONE      = POS_W'(1);

  logic                    busy;
  logic                    off;
  logic signed [POS_W-1:0] ex;
  logic signed [POS_W-1:0] ez;
  logic [MASK_W-1:0]       mask;
  logic [1:0]              row;
  logic [1:0]              col;
  logic [NBR_W-1:0]        idx;

  logic                    accept;
  logic                    step;
  logic                    done;
  logic signed [POS_W-1:0] in_x;
  logic signed [POS_W-1:0] in_z;
  logic                    in_on;
  logic signed [POS_W-1:0] nx;
  logic signed [POS_W-1:0] nz;
  logic                    look;

  assign full   = busy;
  assign accept = push && !busy;
  assign step   = busy && !cmd_full;
  assign done   = off || (idx == NBR_LAST);

  // Classify the incoming centre
  assign in_x  = POS_W'(enter_x);
  assign in_z  = POS_W'(enter_z);
  assign in_on = (in_x >= 0) && (in_x < GRID_LIM) && (in_z >= 0) && (in_z < GRID_LIM);

  // Busy while jobs of the current event remain
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (step && done) begin
      busy <= 1'b0;
    end
  end

  // Latch the event and walk the neighbourhood in row order
  always_ff @(posedge clk) begin
    if (accept) begin
      ex   <= in_x;
      ez   <= in_z;
      mask <= exists_mask;
      off  <= !in_on;
      row  <= '0;
      col  <= '0;
      idx  <= NBR_FIRST;
    end else if (step) begin
      if (col == COL_LAST) begin
        col <= '0;
        row <= row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
      idx <= idx + 1'b1;
    end
  end

  // Build the job for the current neighbour
  assign nx   = ex + $signed(POS_W'(col)) - ONE;
  assign nz   = ez + $signed(POS_W'(row)) - ONE;
  assign look = (nx >= 0) && (nx < GRID_LIM) && (nz >= 0) && (nz < GRID_LIM) && mask[idx];

  assign cmd_push = step;

  always_comb begin
    cmd.kind = (!off && look) ? CMD_LOOK : CMD_PASS;
    cmd.idx  = off ? NBR_FIRST : idx;
    cmd.oob  = off || !mask[NBR_CENTRE];
    cmd.last = done;
    cmd.nx   = nx[IN_COORD_W-1:0];
    cmd.nz   = nz[IN_COORD_W-1:0];
    cmd.cx   = ex[IN_COORD_W-1:0];
    cmd.cz   = ez[IN_COORD_W-1:0];
  end

endmodule

/* rtl/core/tcfe_back.sv */
// Back end: tag lookup, fill and farthest-distance eviction over the slot array.
module tcfe_back #(
  parameter int CACHE_SLOTS = tcfe_pkg::CACHE_SLOTS_DEF,
  parameter int GRID_SIZE   = tcfe_pkg::GRID_SIZE_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  tcfe_pkg::cmd_t cmd,
  input  logic           cmd_empty,
  output logic           cmd_pop,
  output tcfe_pkg::res_t res,
  output logic           res_push,
  input  logic           res_full
);

  import tcfe_pkg::*;

  localparam int SLOT_W     = $clog2(CACHE_SLOTS);
  localparam int COORD_W    = $clog2(GRID_SIZE);
  localparam int DIST_W     = COORD_W + 1;
  localparam int LANE_W     = $clog2(SCAN_LANES);
  localparam int SCAN_STEPS = (CACHE_SLOTS + SCAN_LANES - 1) / SCAN_LANES;
  localparam int STEP_W     = $clog2(SCAN_STEPS);
  localparam int SCAN_DEPTH = SCAN_STEPS * SCAN_LANES;
  localparam int VIC_W      = STEP_W + LANE_W;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SCAN_STEPS - 1);

  function automatic logic [DIST_W-1:0] absd(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
    return (a > b) ? DIST_W'(a - b) : DIST_W'(b - a);
  endfunction

  // Slot array: tags in flops for the parallel compare
  logic [CACHE_SLOTS-1:0] sval;
  logic [COORD_W-1:0]     sx [CACHE_SLOTS];
  logic [COORD_W-1:0]     sz [CACHE_SLOTS];

  bk_state_t st;
  bk_state_t st_next;

  // Lookup results
  logic              lk_hit;
  logic              lk_emp;
  logic [SLOT_W-1:0] lk_hit_slot;
  logic [SLOT_W-1:0] lk_emp_slot;

  // Eviction search shift line and running best
  logic [DIST_W-1:0]  dsh [SCAN_DEPTH];
  logic [COORD_W-1:0] csx [SCAN_DEPTH];
  logic [COORD_W-1:0] csz [SCAN_DEPTH];
  logic [DIST_W-1:0]  best;
  logic [VIC_W-1:0]   victim;
  logic [COORD_W-1:0] vx;
  logic [COORD_W-1:0] vz;
  logic [STEP_W-1:0]  step;

  logic [COORD_W-1:0]     kx;
  logic [COORD_W-1:0]     kz;
  logic [COORD_W-1:0]     cx;
  logic [COORD_W-1:0]     cz;
  logic [CACHE_SLOTS-1:0] hitv;
  logic                   hit_any;
  logic                   emp_any;
  logic [SLOT_W-1:0]      hit_slot;
  logic [SLOT_W-1:0]      emp_slot;
  logic [DIST_W-1:0]      ldist [SCAN_DEPTH];
  logic [COORD_W-1:0]     lx [SCAN_DEPTH];
  logic [COORD_W-1:0]     lz [SCAN_DEPTH];
  logic [DIST_W-1:0]      sc_best;
  logic [VIC_W-1:0]       sc_vic;
  logic [COORD_W-1:0]     sc_x;
  logic [COORD_W-1:0]     sc_z;
  logic                   wr_en;
  logic [SLOT_W-1:0]      wslot;

  assign kx = cmd.nx[COORD_W-1:0];
  assign kz = cmd.nz[COORD_W-1:0];
  assign cx = cmd.cx[COORD_W-1:0];
  assign cz = cmd.cz[COORD_W-1:0];

  // Compare the key against every resident tag
  always_comb begin
    for (int i = 0; i < CACHE_SLOTS; i++) begin
      hitv[i] = sval[i] && (sx[i] == kx) && (sz[i] == kz);
    end
  end

  assign hit_any = |hitv;
  assign emp_any = ~&sval;

  // Pick the lowest matching and the lowest empty slot
  always_comb begin
    hit_slot = '0;
    emp_slot = '0;
    for (int i = CACHE_SLOTS - 1; i >= 0; i--) begin
      if (hitv[i]) begin
        hit_slot = SLOT_W'(i);
      end
      if (!sval[i]) begin
        emp_slot = SLOT_W'(i);
      end
    end
  end

  // Per-slot distance from the centre, padded lanes read as zero
  for (genvar gk = 0; gk < SCAN_DEPTH; gk++) begin : g_lane
    if (gk < CACHE_SLOTS) begin : g_real
      assign ldist[gk] = absd(sx[gk], cx) + absd(sz[gk], cz);
      assign lx[gk]    = sx[gk];
      assign lz[gk]    = sz[gk];
    end else begin : g_pad
      assign ldist[gk] = '0;
      assign lx[gk]    = '0;
      assign lz[gk]    = '0;
    end
  end

  // Fold one group of lanes into the running maximum, first wins on ties
  always_comb begin
    sc_best = best;
    sc_vic  = victim;
    sc_x    = vx;
    sc_z    = vz;
    for (int j = 0; j < SCAN_LANES; j++) begin
      if (dsh[j] > sc_best) begin
        sc_best = dsh[j];
        sc_vic  = {step, LANE_W'(j)};
        sc_x    = csx[j];
        sc_z    = csz[j];
      end
    end
  end

  // Next state
  always_comb begin
    st_next = st;
    case (st)
      BK_IDLE: begin
        if (!cmd_empty && cmd.kind == CMD_LOOK) begin
          st_next = BK_DECIDE;
        end
      end
      BK_DECIDE: begin
        if (lk_hit || lk_emp) begin
          if (!res_full) begin
            st_next = BK_IDLE;
          end
        end else begin
          st_next = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (step == STEP_LAST) begin
          st_next = BK_EVICT;
        end
      end
      BK_EVICT: begin
        if (!res_full) begin
          st_next = BK_IDLE;
        end
      end
      default: st_next = BK_IDLE;
    endcase
  end

  // Outputs: result transaction, job retire and slot write
  always_comb begin
    cmd_pop             = 1'b0;
    res_push            = 1'b0;
    wr_en               = 1'b0;
    wslot               = lk_emp_slot;
    res.neighbour_index = cmd.idx;
    res.out_of_bounds   = cmd.oob;
    res.loaded          = 1'b0;
    res.hit             = 1'b0;
    res.slot            = '0;
    res.evicted         = 1'b0;
    res.evicted_x       = '0;
    res.evicted_z       = '0;
    res.last            = cmd.last;
    case (st)
      BK_IDLE: begin
        if (!cmd_empty && cmd.kind == CMD_PASS && !res_full) begin
          res_push = 1'b1;
          cmd_pop  = 1'b1;
        end
      end
      BK_DECIDE: begin
        if ((lk_hit || lk_emp) && !res_full) begin
          res_push   = 1'b1;
          cmd_pop    = 1'b1;
          wr_en      = !lk_hit;
          res.loaded = 1'b1;
          res.hit    = lk_hit;
          res.slot   = SLOT_OUT_W'(32'(lk_hit ? lk_hit_slot : lk_emp_slot));
        end
      end
      BK_EVICT: begin
        wslot = victim[SLOT_W-1:0];
        if (!res_full) begin
          res_push      = 1'b1;
          cmd_pop       = 1'b1;
          wr_en         = 1'b1;
          res.loaded    = 1'b1;
          res.slot      = SLOT_OUT_W'(32'(victim[SLOT_W-1:0]));
          res.evicted   = 1'b1;
          res.evicted_x = EV_COORD_W'(32'(vx));
          res.evicted_z = EV_COORD_W'(32'(vz));
        end
      end
      BK_SCAN: begin
        cmd_pop = 1'b0;
      end
      default: begin
        cmd_pop = 1'b0;
      end
    endcase
  end

  // Control state and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= BK_IDLE;
      sval <= '0;
    end else begin
      st <= st_next;
      if (wr_en) begin
        sval[wslot] <= 1'b1;
      end
    end
  end

  // Tag write on fill or eviction
  always_ff @(posedge clk) begin
    if (wr_en) begin
      sx[wslot] <= kx;
      sz[wslot] <= kz;
    end
  end

  // Register the lookup, then shift the distance line through the search
  always_ff @(posedge clk) begin
    if (st == BK_IDLE) begin
      lk_hit      <= hit_any;
      lk_emp      <= emp_any;
      lk_hit_slot <= hit_slot;
      lk_emp_slot <= emp_slot;
      best        <= '0;
      victim      <= '0;
      vx          <= lx[0];
      vz          <= lz[0];
      step        <= '0;
      for (int k = 0; k < SCAN_DEPTH; k++) begin
        dsh[k] <= ldist[k];
        csx[k] <= lx[k];
        csz[k] <= lz[k];
      end
    end else if (st == BK_SCAN) begin
      best   <= sc_best;
      victim <= sc_vic;
      vx     <= sc_x;
      vz     <= sc_z;
      step   <= step + 1'b1;
      for (int k = 0; k < SCAN_DEPTH - SCAN_LANES; k++) begin
        dsh[k] <= dsh[k + SCAN_LANES];
        csx[k] <= csx[k + SCAN_LANES];
        csz[k] <= csz[k + SCAN_LANES];
      end
      for (int k = SCAN_DEPTH - SCAN_LANES; k < SCAN_DEPTH; k++) begin
        dsh[k] <= '0;
        csx[k] <= '0;
        csz[k] <= '0;
      end
    end
  end

endmodule

/* rtl/core/tcfe_checker.sv */
// Port-level checks for the tile cache, bound to the top level.
module tcfe_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              full,
  input logic                              empty,
  input logic                              pop,
  input logic [tcfe_pkg::NBR_W-1:0]        neighbour_index,
  input logic                              out_of_bounds,
  input logic                              loaded,
  input logic                              hit,
  input logic [tcfe_pkg::SLOT_OUT_W-1:0]   slot,
  input logic                              evicted,
  input logic                              last
);

  import tcfe_pkg::*;

  // Reset leaves both sides idle
  a_reset_idle: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not idle after reset");

  // An unloaded neighbour carries no slot information
  a_unloaded_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && !loaded) |-> (!hit && !evicted && slot == '0))
    else $error("unloaded result carries slot data");

  // A hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    (!empty && hit) |-> (loaded && !evicted))
    else $error("hit result marked as eviction");

  // Final result of an event not flagged out of bounds is the last neighbour
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (!empty && last && !out_of_bounds) |-> (neighbour_index == NBR_LAST))
    else $error("last result on wrong neighbour");

  // A waiting result holds while not popped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(neighbour_index) && $stable(slot)))
    else $error("waiting result changed");

endmodule

bind tile_cache_farthest_eviction tcfe_checker u_tcfe_checker (
  .clk             (clk),
  .rst             (rst),
  .full            (full),
  .empty           (empty),
  .pop             (pop),
  .neighbour_index (neighbour_index),
  .out_of_bounds   (out_of_bounds),
  .loaded          (loaded),
  .hit             (hit),
  .slot            (slot),
  .evicted         (evicted),
  .last            (last)
);
